>>> hdl/assert_macros.svh
// Assertion macros shared by the queue and back-end RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// The condition must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	`ASSERT_AT(lbl, clk, rst_n, !(cond), msg)

`endif

>>> hdl/ppp_pkg.sv
`default_nettype none
package ppp_pkg;

	localparam int QUEUE_DEPTH_DEF = 4;
	localparam int CLIP_W = 50;
	localparam int QBITS = 32;

	localparam logic [2:0] CFG_ROW0 = 3'd0;
	localparam logic [2:0] CFG_ROW1 = 3'd1;
	localparam logic [2:0] CFG_ROW2 = 3'd2;
	localparam logic [2:0] CFG_ROW3 = 3'd3;
	localparam logic [2:0] CFG_SHOW = 3'd4;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
	} in_t;

	typedef struct packed {
		logic signed [31:0] ndc_x;
		logic signed [31:0] ndc_y;
		logic is_marker;
	} out_t;

	typedef struct packed {
		logic signed [CLIP_W-1:0] cx;
		logic signed [CLIP_W-1:0] cy;
		logic signed [CLIP_W-1:0] cw;
	} clip_t;

	typedef struct packed {
		logic neg_x;
		logic neg_y;
		logic ovf_x;
		logic ovf_y;
		logic [CLIP_W-1:0] d;
		logic [15:0] nlo_x;
		logic [15:0] nlo_y;
		logic [CLIP_W-1:0] rem_x;
		logic [CLIP_W-1:0] rem_y;
		logic [QBITS-1:0] q_x;
		logic [QBITS-1:0] q_y;
	} div_t;

endpackage
`default_nettype wire

>>> hdl/ppp_front.sv
`default_nettype none
module ppp_front
	import ppp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire in_t         point,
	input  wire logic [63:0] row0,
	input  wire logic [63:0] row1,
	input  wire logic [63:0] row3,
	output logic             q_push,
	output clip_t            q_data,
	input  wire logic        q_full
);

	logic signed [47:0] prod_s1 [3][4];
	logic signed [48:0] half_s2 [3][2];
	logic signed [CLIP_W-1:0] sum_s3 [3];
	logic v_s1, v_s2, v_s3;
	logic en;
	logic [63:0] rows [3];
	logic signed [31:0] coords [3];

	assign rows[0] = row0;
	assign rows[1] = row1;
	assign rows[2] = row3;
	assign coords[0] = point.point_x;
	assign coords[1] = point.point_y;
	assign coords[2] = point.point_z;

	assign en = !(v_s3 && (sum_s3[2] != '0) && q_full);
	assign full = !en;
	assign q_push = v_s3 && (sum_s3[2] != '0) && !q_full;
	assign q_data = '{cx: sum_s3[0], cy: sum_s3[1], cw: sum_s3[2]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s1[r][c] <= $signed(rows[r][c*16 +: 16]) * coords[c];
				end
				prod_s1[r][3] <= 48'($signed({rows[r][63:48], 16'h0000}));
				half_s2[r][0] <= 49'(prod_s1[r][0]) + 49'(prod_s1[r][1]);
				half_s2[r][1] <= 49'(prod_s1[r][2]) + 49'(prod_s1[r][3]);
				sum_s3[r] <= CLIP_W'(half_s2[r][0]) + CLIP_W'(half_s2[r][1]);
			end
		end
	end

endmodule
`default_nettype wire

>>> hdl/ppp_queue.sv
`default_nettype none
`include "assert_macros.svh"
module ppp_queue
	import ppp_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire clip_t din,
	output logic       full,
	input  wire logic  pop,
	output clip_t      dout,
	output logic       empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	clip_t mem [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic do_push, do_pop;

	assign full = (cnt_q == CW'(DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign dout = mem[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + CW'(do_push) - CW'(do_pop);
		end
	end

	`ASSERT_NEVER(a_no_overrun, clk, arst_n, push && full, "push while queue full")
	`ASSERT_AT(a_cnt_range, clk, arst_n, cnt_q <= CW'(DEPTH), "queue count beyond depth")

endmodule
`default_nettype wire

>>> hdl/ppp_back.sv
`default_nettype none
`include "assert_macros.svh"
module ppp_back
	import ppp_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  q_empty,
	output logic       q_pop,
	input  wire clip_t q_data,
	input  wire logic  show,
	input  wire logic  pop,
	output logic       empty,
	output out_t       result
);

	logic adv;
	logic v_s1;
	logic [CLIP_W-1:0] nx_s1, ny_s1, d_s1;
	logic negx_s1, negy_s1;
	div_t dstage_s [QBITS+1];
	div_t dnext [QBITS];
	logic dv_s [QBITS+1];
	logic out_v_q;
	out_t res_q;
	div_t fin;

	assign adv = !(out_v_q && !pop);
	assign q_pop = adv && !q_empty;
	assign empty = !out_v_q;
	assign result = res_q;
	assign fin = dstage_s[QBITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			for (int i = 0; i <= QBITS; i++) begin
				dv_s[i] <= 1'b0;
			end
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_s1 <= q_pop;
			dv_s[0] <= v_s1;
			for (int i = 0; i < QBITS; i++) begin
				dv_s[i+1] <= dv_s[i];
			end
			out_v_q <= dv_s[QBITS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			negx_s1 <= q_data.cx[CLIP_W-1] != q_data.cw[CLIP_W-1];
			negy_s1 <= q_data.cy[CLIP_W-1] != q_data.cw[CLIP_W-1];
			nx_s1 <= q_data.cx[CLIP_W-1] ? CLIP_W'(-q_data.cx) : CLIP_W'(q_data.cx);
			ny_s1 <= q_data.cy[CLIP_W-1] ? CLIP_W'(-q_data.cy) : CLIP_W'(q_data.cy);
			d_s1 <= q_data.cw[CLIP_W-1] ? CLIP_W'(-q_data.cw) : CLIP_W'(q_data.cw);
			dstage_s[0].neg_x <= negx_s1;
			dstage_s[0].neg_y <= negy_s1;
			dstage_s[0].ovf_x <= {16'h0000, nx_s1[CLIP_W-1:16]} >= d_s1;
			dstage_s[0].ovf_y <= {16'h0000, ny_s1[CLIP_W-1:16]} >= d_s1;
			dstage_s[0].d <= d_s1;
			dstage_s[0].nlo_x <= nx_s1[15:0];
			dstage_s[0].nlo_y <= ny_s1[15:0];
			dstage_s[0].rem_x <= {16'h0000, nx_s1[CLIP_W-1:16]};
			dstage_s[0].rem_y <= {16'h0000, ny_s1[CLIP_W-1:16]};
			dstage_s[0].q_x <= '0;
			dstage_s[0].q_y <= '0;
			for (int i = 0; i < QBITS; i++) begin
				dstage_s[i+1] <= dnext[i];
			end
		end
	end

	for (genvar j = 0; j < QBITS; j++) begin : g_div
		localparam int K = QBITS - 1 - j;
		logic bx, by, gex, gey;
		logic [CLIP_W:0] shx, shy;
		div_t nxt;
		if (K >= 16) begin : g_num
			assign bx = dstage_s[j].nlo_x[K-16];
			assign by = dstage_s[j].nlo_y[K-16];
		end else begin : g_zero
			assign bx = 1'b0;
			assign by = 1'b0;
		end
		assign shx = {dstage_s[j].rem_x, bx};
		assign shy = {dstage_s[j].rem_y, by};
		assign gex = shx >= {1'b0, dstage_s[j].d};
		assign gey = shy >= {1'b0, dstage_s[j].d};

		always_comb begin
			nxt = dstage_s[j];
			nxt.rem_x = gex ? CLIP_W'(shx - {1'b0, dstage_s[j].d}) : shx[CLIP_W-1:0];
			nxt.rem_y = gey ? CLIP_W'(shy - {1'b0, dstage_s[j].d}) : shy[CLIP_W-1:0];
			nxt.q_x = {dstage_s[j].q_x[QBITS-2:0], gex};
			nxt.q_y = {dstage_s[j].q_y[QBITS-2:0], gey};
		end

		assign dnext[j] = nxt;
	end

	function automatic logic [31:0] sat_q(logic neg, logic ovf, logic [31:0] q);
		logic [31:0] r;
		if (neg) begin
			r = (ovf || q > 32'h8000_0000) ? 32'h8000_0000 : 32'(-q);
		end else begin
			r = (ovf || q[31]) ? 32'h7FFF_FFFF : q;
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.ndc_x <= $signed(sat_q(fin.neg_x, fin.ovf_x, fin.q_x));
			res_q.ndc_y <= $signed(sat_q(fin.neg_y, fin.ovf_y, fin.q_y));
			res_q.is_marker <= show;
		end
	end

	`ASSERT_AT(a_out_hold, clk, arst_n, (out_v_q && !pop) |=> out_v_q,
		"stalled result lost")

endmodule
`default_nettype wire

>>> hdl/perspective_point_projection_unit.sv
// A point passes the front stages, the queue, the divider stages and the result register.
// Throughput: one point per cycle unless stalled; the 32 stage divider is fully pipelined.
// Points whose clip w is zero leave the pipeline after the front stages and give no result.
// Reset: arst_n is asynchronous and active low; it empties every stage and the queue,
// and clears the matrix rows and the marker flag, so every point is dropped until written.
`default_nettype none
module perspective_point_projection_unit
	import ppp_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire in_t         point,
	input  wire logic        pop,
	output logic             empty,
	output out_t             result,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [63:0] cfg_data
);

	logic [63:0] row0_q, row1_q, row2_q, row3_q;
	logic show_q;
	logic fq_push, fq_full, bq_pop, bq_empty;
	clip_t fq_data, bq_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row0_q <= '0;
			row1_q <= '0;
			row2_q <= '0;
			row3_q <= '0;
			show_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ROW0: row0_q <= cfg_data;
				CFG_ROW1: row1_q <= cfg_data;
				CFG_ROW2: row2_q <= cfg_data;
				CFG_ROW3: row3_q <= cfg_data;
				CFG_SHOW: show_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	ppp_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.point  (point),
		.row0   (row0_q),
		.row1   (row1_q),
		.row3   (row3_q ^ (row2_q & 64'h0)),
		.q_push (fq_push),
		.q_data (fq_data),
		.q_full (fq_full)
	);

	ppp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fq_push),
		.din    (fq_data),
		.full   (fq_full),
		.pop    (bq_pop),
		.dout   (bq_data),
		.empty  (bq_empty)
	);

	ppp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (bq_empty),
		.q_pop   (bq_pop),
		.q_data  (bq_data),
		.show    (show_q),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

endmodule
`default_nettype wire

>>> bench/perspective_point_projection_unit_tb.sv
`default_nettype none
module perspective_point_projection_unit_tb
	import ppp_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] CFG_UNUSED = 3'd7;
	localparam int DRAIN_CYCLES = 60;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [3:0][63:0] rows;
		logic [63:0] show;
	} matrix_cfg_t;

	typedef struct packed {
		logic [2:0] setting;
		in_t p;
		logic typed;
		logic drop;
		logic [31:0] ex;
		logic [31:0] ey;
	} point_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	in_t point = '0;
	logic pop = 1'b0;
	logic empty;
	out_t result;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = CFG_ROW0;
	logic [63:0] cfg_data = '0;

	logic typed_now = 1'b0;
	logic typed_drop = 1'b0;
	logic [31:0] typed_x = '0;
	logic [31:0] typed_y = '0;

	logic [3:0][63:0] model_rows = '0;
	logic model_show = 1'b0;
	out_t ndc_expected[$];
	bit failed = 0;
	int unsigned cycles = 0;

	perspective_point_projection_unit dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .point(point),
		.pop(pop), .empty(empty), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic longint coef(logic [63:0] row, int c);
		return longint'($signed(row[c*16 +: 16]));
	endfunction

	function automatic longint clip_dot(logic [63:0] row, in_t p);
		return coef(row, 0) * longint'(p.point_x) + coef(row, 1) * longint'(p.point_y)
			+ coef(row, 2) * longint'(p.point_z) + coef(row, 3) * 65536;
	endfunction

	function automatic logic [31:0] ndc_divide(longint num, longint den);
		logic neg;
		logic [63:0] n;
		logic [63:0] d;
		logic [127:0] q;
		neg = (num < 0) != (den < 0);
		n = num < 0 ? -num : num;
		d = den < 0 ? -den : den;
		q = ({64'd0, n} << 16) / {64'd0, d};
		if (neg) begin
			if (q > 128'h8000_0000)
				q = 128'h8000_0000;
			return -q[31:0];
		end
		if (q > 128'h7FFF_FFFF)
			q = 128'h7FFF_FFFF;
		return q[31:0];
	endfunction

	function automatic bit project_point(in_t p, output out_t r);
		longint cw;
		cw = clip_dot(model_rows[3], p);
		r = '0;
		if (cw == 0)
			return 0;
		r.ndc_x = ndc_divide(clip_dot(model_rows[0], p), cw);
		r.ndc_y = ndc_divide(clip_dot(model_rows[1], p), cw);
		r.is_marker = model_show;
		return 1;
	endfunction

	always @(posedge clk) begin
		out_t r;
		out_t e;
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
		if (arst_n && push && !full) begin
			if (typed_now) begin
				if (!typed_drop) begin
					r = {typed_x, typed_y, model_show};
					ndc_expected.insert(ndc_expected.size(), r);
				end
			end else if (project_point(point, r)) begin
				ndc_expected.insert(ndc_expected.size(), r);
			end
		end
		if (arst_n && pop && !empty) begin
			if (ndc_expected.size() == 0) begin
				$error("unexpected result transfer %h", result);
				failed = 1;
			end else begin
				e = ndc_expected.pop_front();
				if (result.ndc_x !== e.ndc_x) begin
					$error("ndc_x expected %h actual %h", e.ndc_x, result.ndc_x);
					failed = 1;
				end
				if (result.ndc_y !== e.ndc_y) begin
					$error("ndc_y expected %h actual %h", e.ndc_y, result.ndc_y);
					failed = 1;
				end
				if (result.is_marker !== e.is_marker) begin
					$error("is_marker expected %b actual %b", e.is_marker, result.is_marker);
					failed = 1;
				end
			end
		end
	end

	// The receiver alternates between stretches of steady popping and random stalls.
	always @(posedge clk) begin
		if ((cycles / 97) % 3 == 0)
			pop <= 1'b1;
		else
			pop <= ($urandom_range(0, 3) != 0);
	end

	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (ndc_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_matrix(matrix_cfg_t m);
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= 3'(i);
			cfg_data <= m.rows[i];
			model_rows[i] = m.rows[i];
			@(posedge clk);
		end
		cfg_index <= CFG_SHOW;
		cfg_data <= m.show;
		model_show = m.show[0];
		@(posedge clk);
		cfg_index <= CFG_UNUSED;
		cfg_data <= {$urandom, $urandom};
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	int burst_left = 0;

	task automatic send_point(in_t p, logic t, logic dr, logic [31:0] ex, logic [31:0] ey);
		if (burst_left == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 12);
		end
		burst_left--;
		push <= 1'b1;
		point <= p;
		typed_now <= t;
		typed_drop <= dr;
		typed_x <= ex;
		typed_y <= ey;
		do
			@(posedge clk);
		while (full);
	endtask

	function automatic logic [31:0] rand_coord(bit wide);
		return wide ? $urandom : 32'($signed($urandom_range(0, 32'h7FFFF)) - 32'h40000);
	endfunction

	function automatic logic [15:0] rand_coef();
		case ($urandom_range(0, 3))
			0: return 16'($urandom);
			1: return 16'h7FFF;
			2: return 16'h8000;
			default: return 16'($signed($urandom_range(0, 16'h3FFF)) - 16'h2000);
		endcase
	endfunction

	matrix_cfg_t settings[5];
	point_row_t directed[22];

	initial begin
		matrix_cfg_t m;
		in_t p;
		int cur;
		bit persp;
		settings[0] = '0;
		settings[1] = {64'h1000_0000_0000_0000, 64'h0, 64'h0000_0000_1000_0000,
			64'h0000_0000_0000_1000, 64'h1};
		settings[2] = {64'h0000_1000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
			64'h0000_0000_1000_0000, 64'h0000_0000_0000_1000, 64'hAAAA_AAAA_AAAA_AAA0};
		settings[3] = {64'h0001_0000_0000_0000, 64'h8000_8000_8000_8000,
			64'h0000_0000_0000_8000, 64'h0000_0000_0000_7FFF, 64'hFFFF_FFFF_FFFF_FFFF};
		settings[4] = {64'h8000_7FFF_FFFF_0001, 64'h7FFF_7FFF_7FFF_7FFF,
			64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_8000_0001_FFFF, 64'h0};
		directed = '{
			'{0, '{32'h0, 32'h0, 32'h0}, 1, 1, 0, 0},
			'{0, '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF}, 1, 1, 0, 0},
			'{1, '{32'h0, 32'h0, 32'h0}, 1, 0, 32'h0, 32'h0},
			'{1, '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0}, 1, 0, 32'h7FFF_FFFF, 32'h8000_0000},
			'{1, '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF}, 1, 0,
				32'h8000_0000, 32'h7FFF_FFFF},
			'{1, '{32'h0001_0000, 32'hFFFF_0000, 32'h1234_5678}, 1, 0,
				32'h0001_0000, 32'hFFFF_0000},
			'{2, '{32'h0000_1234, 32'h0000_5678, 32'h0}, 1, 1, 0, 0},
			'{2, '{32'h0003_0000, 32'hFFFD_0000, 32'h0001_0000}, 1, 0,
				32'h0003_0000, 32'hFFFD_0000},
			'{2, '{32'h0004_0000, 32'h0, 32'h0002_0000}, 1, 0, 32'h0002_0000, 32'h0},
			'{2, '{32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000}, 1, 0,
				32'hFFFF_0000, 32'hFFFF_0000},
			'{3, '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0}, 1, 0, 32'h7FFF_FFFF, 32'h8000_0000},
			'{3, '{32'h8000_0000, 32'h8000_0000, 32'h0}, 1, 0, 32'h8000_0000, 32'h7FFF_FFFF},
			'{3, '{32'h0, 32'h0, 32'h0}, 1, 0, 32'h0, 32'h0},
			'{3, '{32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF}, 0, 0, 0, 0},
			'{4, '{32'h0, 32'h0, 32'h0}, 0, 0, 0, 0},
			'{4, '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 0, 0, 0, 0},
			'{4, '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 0, 0, 0, 0},
			'{4, '{32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_F0F0}, 0, 0, 0, 0},
			'{4, '{32'h0001_0000, 32'h0002_0000, 32'hFFFF_8000}, 0, 0, 0, 0},
			'{4, '{32'h0000_0001, 32'h0, 32'h0}, 0, 0, 0, 0},
			'{4, '{32'h0, 32'h0000_0001, 32'h0}, 0, 0, 0, 0},
			'{4, '{32'h0, 32'h0, 32'h0000_0001}, 0, 0, 0, 0}
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		cur = 0;
		foreach (directed[i]) begin
			if (directed[i].setting != cur) begin
				drain();
				cur = directed[i].setting;
				load_matrix(settings[cur]);
			end
			send_point(directed[i].p, directed[i].typed, directed[i].drop,
				directed[i].ex, directed[i].ey);
		end
		for (int ph = 0; ph < 6; ph++) begin
			drain();
			persp = (ph % 2 == 0);
			for (int r = 0; r < 4; r++)
				m.rows[r] = {rand_coef(), rand_coef(), rand_coef(), rand_coef()};
			if (persp)
				m.rows[3] = {16'($urandom_range(0, 16'h07FF)), 16'h1000, 32'h0};
			m.show = {$urandom, $urandom};
			load_matrix(m);
			for (int k = 0; k < 125; k++) begin
				p.point_x = rand_coord($urandom_range(0, 3) == 0);
				p.point_y = rand_coord($urandom_range(0, 3) == 0);
				p.point_z = rand_coord($urandom_range(0, 3) == 0);
				if (persp && $urandom_range(0, 7) == 0)
					p.point_z = -(32'(m.rows[3][63:48]) << 4);
				send_point(p, 1'b0, 1'b0, '0, '0);
			end
		end
		drain();
		if (!failed)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
`default_nettype wire

>>> files.f
+incdir+hdl
hdl/ppp_pkg.sv
hdl/ppp_front.sv
hdl/ppp_queue.sv
hdl/ppp_back.sv
hdl/perspective_point_projection_unit.sv
bench/perspective_point_projection_unit_tb.sv
